@@ design/simdmt_pkg.sv @@
// Shared constants, types and command structures of the SIMD Mersenne Twister block.
package simdmt_pkg;

    localparam int RING_ENTRIES = 156;
    localparam int ADDR_W       = $clog2(RING_ENTRIES);
    localparam int POS_W        = $clog2(RING_ENTRIES + 1);
    localparam int WORD_IDX_W   = $clog2(4 * RING_ENTRIES);
    localparam int BI_W         = (ADDR_W > 8) ? ADDR_W : 8;
    localparam int ENTRY_W      = 128;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    localparam logic [ADDR_W-1:0]     ADDR_LAST   = ADDR_W'(RING_ENTRIES - 1);
    localparam logic [ADDR_W-1:0]     ADDR_PENULT = ADDR_W'(RING_ENTRIES - 2);
    localparam logic [POS_W-1:0]      POS_END     = POS_W'(RING_ENTRIES);
    localparam logic [BI_W:0]         BI_RING_N   = (BI_W + 1)'(RING_ENTRIES);
    localparam logic [WORD_IDX_W-1:0] WORD_LAST   = WORD_IDX_W'(4 * RING_ENTRIES - 1);
    localparam logic [31:0]           SEED_MULT   = 32'd1812433253;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PICK_OFFSET      = 3'd0,
        CFG_WORD_LEFT_SHIFT  = 3'd1,
        CFG_BYTE_LEFT_SHIFT  = 3'd2,
        CFG_WORD_RIGHT_SHIFT = 3'd3,
        CFG_BYTE_RIGHT_SHIFT = 3'd4,
        CFG_MASK_LOW         = 3'd5,
        CFG_MASK_HIGH        = 3'd6
    } t_cfg_reg;

    // Ring read address sources.
    typedef enum logic [2:0] {
        RD_POS      = 3'd0,
        RD_PENULT   = 3'd1,
        RD_LAST     = 3'd2,
        RD_ENT      = 3'd3,
        RD_ENT_NEXT = 3'd4,
        RD_BI       = 3'd5
    } t_rd_sel;

    typedef struct packed {
        logic    seed_load;
        logic    seed_step;
        logic    pos_clear;
        logic    pos_incr;
        logic    off_load;
        logic    off_reduce;
        logic    ent_clear;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    lat_c;
        logic    lat_d;
        logic    lat_a;
        logic    regen_write;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic pos_at_end;
        logic seeded;
        logic seed_last;
        logic off_ge_n;
        logic ent_last;
        logic out_busy;
    } t_dp_status;

endpackage

@@ design/simdmt_if.sv @@
// Valid/ready channel interfaces for the generator's commands and results.
interface simdmt_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] seed;

    modport source (output valid, output command, output seed, input ready);
    modport sink   (input valid, input command, input seed, output ready);
endinterface

interface simdmt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;

    modport source (output valid, output word0, output word1, output word2, output word3,
                    input ready);
    modport sink   (input valid, input word0, input word1, input word2, input word3,
                    output ready);
endinterface

@@ design/simdmt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module simdmt_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 156,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/simdmt_ctrl.sv @@
// Controller state machine that sequences seeding, regeneration and fetches.
module simdmt_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_command,
    input  simdmt_pkg::t_dp_status i_status,
    output simdmt_pkg::t_dp_cmd    o_cmd,
    output logic                   o_in_ready
);
    import simdmt_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_SEED   = 10'b00_0000_0010,
        S_MOD    = 10'b00_0000_0100,
        S_PRE_C  = 10'b00_0000_1000,
        S_PRE_D  = 10'b00_0001_0000,
        S_RG_A   = 10'b00_0010_0000,
        S_RG_B   = 10'b00_0100_0000,
        S_RG_W   = 10'b00_1000_0000,
        S_FT_RD  = 10'b01_0000_0000,
        S_FT_OUT = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel = RD_POS;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    if (!i_command) begin
                        o_cmd.seed_load = 1'b1;
                        o_cmd.pos_clear = 1'b1;
                        n_state = S_SEED;
                    end else if (i_status.pos_at_end && i_status.seeded) begin
                        o_cmd.off_load = 1'b1;
                        n_state = S_MOD;
                    end else begin
                        // An unseeded ring is all zeros and stays so through regeneration.
                        o_cmd.pos_clear = i_status.pos_at_end;
                        n_state = S_FT_RD;
                    end
                end
            end
            S_SEED: begin
                o_cmd.seed_step = 1'b1;
                if (i_status.seed_last) begin
                    n_state = S_IDLE;
                end
            end
            S_MOD: begin
                if (i_status.off_ge_n) begin
                    o_cmd.off_reduce = 1'b1;
                end else begin
                    n_state = S_PRE_C;
                end
            end
            S_PRE_C: begin
                o_cmd.ent_clear = 1'b1;
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_sel    = RD_PENULT;
                n_state = S_PRE_D;
            end
            S_PRE_D: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_LAST;
                o_cmd.lat_c  = 1'b1;
                n_state = S_RG_A;
            end
            S_RG_A: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_ENT;
                o_cmd.lat_d  = 1'b1;
                n_state = S_RG_B;
            end
            S_RG_B: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_BI;
                o_cmd.lat_a  = 1'b1;
                n_state = S_RG_W;
            end
            S_RG_W: begin
                o_cmd.regen_write = 1'b1;
                if (i_status.ent_last) begin
                    o_cmd.pos_clear = 1'b1;
                    n_state = S_FT_RD;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_ENT_NEXT;
                    n_state = S_RG_B;
                end
            end
            S_FT_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_POS;
                n_state = S_FT_OUT;
            end
            S_FT_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.pos_incr = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ design/simdmt_dp.sv @@
// Datapath: configuration registers, seeding unit, recurrence logic and output register.
module simdmt_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  simdmt_pkg::t_dp_cmd                  i_cmd,
    output simdmt_pkg::t_dp_status               o_status,
    input  logic [31:0]                          i_seed,
    input  logic                                 i_cfg_we,
    input  logic [simdmt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [simdmt_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output logic                                 o_ram_we,
    output logic [simdmt_pkg::ADDR_W-1:0]        o_ram_waddr,
    output logic [simdmt_pkg::ENTRY_W-1:0]       o_ram_wdata,
    output logic                                 o_ram_re,
    output logic [simdmt_pkg::ADDR_W-1:0]        o_ram_raddr,
    input  logic [simdmt_pkg::ENTRY_W-1:0]       i_ram_rdata,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [simdmt_pkg::ENTRY_W-1:0]       o_out_data
);
    import simdmt_pkg::*;

    // Configuration registers.
    logic [7:0]  r_cfg_off;
    logic [4:0]  r_cfg_wls;
    logic [2:0]  r_cfg_bls;
    logic [4:0]  r_cfg_wrs;
    logic [2:0]  r_cfg_brs;
    logic [63:0] r_cfg_mask_lo;
    logic [63:0] r_cfg_mask_hi;

    // Control and position state.
    logic [POS_W-1:0]      r_pos;
    logic                  r_seeded;
    logic                  r_out_valid;
    logic [ADDR_W-1:0]     r_ent;
    logic [BI_W-1:0]       r_bi;
    logic [WORD_IDX_W-1:0] r_word;

    // Payload registers.
    logic [31:0]        r_prev;
    logic [95:0]        r_seed_buf;
    logic [ENTRY_W-1:0] r_a, r_c, r_d, r_out_data;

    logic [31:0]        seed_mix, seed_next;
    logic [ENTRY_W-1:0] a_shl, c_shr, b_shr, d_shl, mix_result;
    logic [ADDR_W-1:0]  bi_addr;
    logic [ADDR_W-1:0]  ent_next;

    assign bi_addr  = r_bi[ADDR_W-1:0];
    assign ent_next = r_ent + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_off     <= 8'd1;
            r_cfg_wls     <= 5'd11;
            r_cfg_bls     <= 3'd7;
            r_cfg_wrs     <= 5'd7;
            r_cfg_brs     <= 3'd7;
            r_cfg_mask_lo <= 64'h0000_0007_0000_0007;
            r_cfg_mask_hi <= 64'h0000_0007_0000_0007;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PICK_OFFSET:      r_cfg_off     <= i_cfg_wdata[7:0];
                CFG_WORD_LEFT_SHIFT:  r_cfg_wls     <= i_cfg_wdata[4:0];
                CFG_BYTE_LEFT_SHIFT:  r_cfg_bls     <= i_cfg_wdata[2:0];
                CFG_WORD_RIGHT_SHIFT: r_cfg_wrs     <= i_cfg_wdata[4:0];
                CFG_BYTE_RIGHT_SHIFT: r_cfg_brs     <= i_cfg_wdata[2:0];
                CFG_MASK_LOW:         r_cfg_mask_lo <= i_cfg_wdata;
                CFG_MASK_HIGH:        r_cfg_mask_hi <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
            r_ent       <= '0;
            r_bi        <= '0;
            r_word      <= '0;
        end else begin
            if (i_cmd.pos_clear) begin
                r_pos <= '0;
            end else if (i_cmd.pos_incr) begin
                r_pos <= r_pos + 1'b1;
            end
            if (i_cmd.seed_load) begin
                r_seeded <= 1'b1;
                r_word   <= '0;
            end else if (i_cmd.seed_step) begin
                r_word <= r_word + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.ent_clear) begin
                r_ent <= '0;
            end else if (i_cmd.regen_write) begin
                r_ent <= ent_next;
            end
            if (i_cmd.off_load) begin
                r_bi <= BI_W'(r_cfg_off);
            end else if (i_cmd.off_reduce) begin
                r_bi <= r_bi - BI_RING_N[BI_W-1:0];
            end else if (i_cmd.regen_write) begin
                r_bi <= (bi_addr == ADDR_LAST) ? '0 : r_bi + 1'b1;
            end
        end
    end

    // Seeding: one 32-bit word per cycle, an entry written every fourth word.
    assign seed_mix  = r_prev ^ (r_prev >> 30);
    assign seed_next = seed_mix * SEED_MULT + 32'(r_word) + 32'd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_load) begin
            r_prev <= i_seed;
        end else if (i_cmd.seed_step) begin
            r_prev <= seed_next;
            case (r_word[1:0])
                2'd0:    r_seed_buf[31:0]  <= r_prev;
                2'd1:    r_seed_buf[63:32] <= r_prev;
                2'd2:    r_seed_buf[95:64] <= r_prev;
                default: begin
                end
            endcase
        end
        if (i_cmd.lat_c) begin
            r_c <= i_ram_rdata;
        end else if (i_cmd.regen_write) begin
            r_c <= r_d;
        end
        if (i_cmd.lat_d) begin
            r_d <= i_ram_rdata;
        end else if (i_cmd.regen_write) begin
            r_d <= mix_result;
        end
        if (i_cmd.lat_a) begin
            r_a <= i_ram_rdata;
        end
        if (i_cmd.out_load) begin
            r_out_data <= r_seeded ? i_ram_rdata : '0;
        end
    end

    // Recurrence: the offset entry arrives straight from the ring read port.
    assign a_shl = r_a << {r_cfg_bls, 3'b000};
    assign c_shr = r_c >> {r_cfg_brs, 3'b000};

    always_comb begin
        for (int w = 0; w < 4; w++) begin
            b_shr[32*w +: 32] = i_ram_rdata[32*w +: 32] >> r_cfg_wrs;
            d_shl[32*w +: 32] = r_d[32*w +: 32] << r_cfg_wls;
        end
    end

    assign mix_result = r_a ^ a_shl ^ (b_shr & {r_cfg_mask_hi, r_cfg_mask_lo}) ^ c_shr ^ d_shl;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_POS:      o_ram_raddr = r_pos[ADDR_W-1:0];
            RD_PENULT:   o_ram_raddr = ADDR_PENULT;
            RD_LAST:     o_ram_raddr = ADDR_LAST;
            RD_ENT:      o_ram_raddr = r_ent;
            RD_ENT_NEXT: o_ram_raddr = ent_next;
            RD_BI:       o_ram_raddr = bi_addr;
            default:     o_ram_raddr = r_pos[ADDR_W-1:0];
        endcase
    end

    assign o_ram_re    = i_cmd.rd_en;
    assign o_ram_we    = (i_cmd.seed_step && (r_word[1:0] == 2'd3)) || i_cmd.regen_write;
    assign o_ram_waddr = i_cmd.regen_write ? r_ent : r_word[WORD_IDX_W-1:2];
    assign o_ram_wdata = i_cmd.regen_write ? mix_result : {r_prev, r_seed_buf};

    assign o_status.pos_at_end = (r_pos == POS_END);
    assign o_status.seeded     = r_seeded;
    assign o_status.seed_last  = (r_word == WORD_LAST);
    assign o_status.off_ge_n   = ({1'b0, r_bi} >= BI_RING_N);
    assign o_status.ent_last   = (r_ent == ADDR_LAST);
    assign o_status.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ design/simd_fast_mersenne_twister.sv @@
// Top level of the SIMD-oriented Mersenne Twister generator with programmable recurrence.
// Fetch: the ring entry at the read position is read, then loaded into the output register
// once that is free; only then is a new command taken. A fetch that starts a new pass
// first regenerates the ring, an entry per S_RG_B/S_RG_W pair (one ring read port serves
// the current and offset entries). Seed: 4*156 32-bit words, one per cycle through the
// seeding multiplier. Reset (synchronous, active low) restores the register defaults and
// position 0; the ring reads as zeros until the first seed, so no clearing pass is needed.
module simd_fast_mersenne_twister (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    simdmt_in_if.sink                            i_cmd,
    simdmt_out_if.source                         o_rnd,
    input  logic                                 i_cfg_we,
    input  logic [simdmt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [simdmt_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import simdmt_pkg::*;

    t_dp_cmd              dp_cmd;
    t_dp_status           dp_status;
    logic                 in_ready;
    logic                 in_accept;
    logic                 ram_we, ram_re;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;
    logic [ENTRY_W-1:0]   out_data;
    logic                 out_valid;

    // A command transaction is taken only while the controller is idle; a finished
    // result sits in the output register, so a seed may be taken while it waits.
    // Regeneration starts with a reduction step in S_MOD when the offset register is at
    // least the ring size and has to be reduced first.
    assign i_cmd.ready = in_ready;
    assign in_accept   = i_cmd.valid && in_ready;

    simdmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_command  (i_cmd.command),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_in_ready (in_ready)
    );

    simdmt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_seed      (i_cmd.seed),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_out_valid (out_valid),
        .i_out_ready (o_rnd.ready),
        .o_out_data  (out_data)
    );

    // The ring of 128-bit entries; the two previous entries of the recurrence live in
    // datapath registers, so regeneration needs only the current and offset reads.
    simdmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_ENTRIES)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_rnd.valid = out_valid;
    assign o_rnd.word0 = out_data[31:0];
    assign o_rnd.word1 = out_data[63:32];
    assign o_rnd.word2 = out_data[95:64];
    assign o_rnd.word3 = out_data[127:96];

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the SIMD Mersenne Twister generator top level.
`timescale 1ns / 1ps

module tb;
    import simdmt_pkg::*;

    // Command codes carried on the command channel.
    typedef enum logic {
        CMD_SEED  = 1'b0,
        CMD_FETCH = 1'b1
    } t_command;

    // Register index that the block does not decode; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

    localparam logic [31:0] INIT_MULT = 32'd1812433253;

    // Long enough for a full seed or a regenerating fetch to finish, so this many idle
    // cycles after the last result guarantees that the block has gone quiet.
    localparam int SETTLE_CYCLES = 6 * RING_ENTRIES + 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int LIMIT_CYCLES  = 600000;
    localparam int PHASE_ITEMS   = 285;

    // One complete set of recurrence parameters.
    typedef struct packed {
        logic [7:0]  pick_offset;
        logic [4:0]  word_lsh;
        logic [2:0]  byte_lsh;
        logic [4:0]  word_rsh;
        logic [2:0]  byte_rsh;
        logic [63:0] mask_lo;
        logic [63:0] mask_hi;
    } t_gen_cfg;

    // Predicts the entries that the generator returns and checks them in order.
    class rng_scoreboard;
        logic [127:0] ring [RING_ENTRIES];
        int unsigned  read_pos;
        logic [7:0]   pick_offset;
        logic [4:0]   word_lsh;
        logic [2:0]   byte_lsh;
        logic [4:0]   word_rsh;
        logic [2:0]   byte_rsh;
        logic [63:0]  mask_lo;
        logic [63:0]  mask_hi;
        logic [127:0] pending_entries [$];
        int           mismatches;
        int           seeds_seen;
        int           fetches_seen;
        int           passes_regenerated;
        int           entries_checked;

        function new();
            for (int e = 0; e < RING_ENTRIES; e++) ring[e] = '0;
            read_pos    = 0;
            pick_offset = 8'd1;
            word_lsh    = 5'd11;
            byte_lsh    = 3'd7;
            word_rsh    = 5'd7;
            byte_rsh    = 3'd7;
            mask_lo     = 64'h0000_0007_0000_0007;
            mask_hi     = 64'h0000_0007_0000_0007;
            mismatches = 0;
            seeds_seen = 0;
            fetches_seen = 0;
            passes_regenerated = 0;
            entries_checked = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
            case (idx)
                CFG_PICK_OFFSET:      pick_offset = data[7:0];
                CFG_WORD_LEFT_SHIFT:  word_lsh    = data[4:0];
                CFG_BYTE_LEFT_SHIFT:  byte_lsh    = data[2:0];
                CFG_WORD_RIGHT_SHIFT: word_rsh    = data[4:0];
                CFG_BYTE_RIGHT_SHIFT: byte_rsh    = data[2:0];
                CFG_MASK_LOW:         mask_lo     = data;
                CFG_MASK_HIGH:        mask_hi     = data;
                default: ;
            endcase
        endfunction

        function void regenerate();
            logic [127:0] a, b, c, d, b_sh, d_sh;
            int unsigned  bi;
            for (int i = 0; i < RING_ENTRIES; i++) begin
                bi = (i + pick_offset) % RING_ENTRIES;
                a  = ring[i];
                b  = ring[bi];
                c  = ring[(i + RING_ENTRIES - 2) % RING_ENTRIES];
                d  = ring[(i + RING_ENTRIES - 1) % RING_ENTRIES];
                for (int w = 0; w < 4; w++) begin
                    b_sh[32*w +: 32] = b[32*w +: 32] >> word_rsh;
                    d_sh[32*w +: 32] = d[32*w +: 32] << word_lsh;
                end
                ring[i] = a ^ (a << (8 * byte_lsh)) ^ (b_sh & {mask_hi, mask_lo})
                        ^ (c >> (8 * byte_rsh)) ^ d_sh;
            end
            passes_regenerated++;
        endfunction

        function void note_command(t_command cmd, logic [31:0] seed);
            logic [31:0] prev;
            if (cmd == CMD_SEED) begin
                prev = seed;
                ring[0][31:0] = prev;
                for (int k = 1; k < 4 * RING_ENTRIES; k++) begin
                    prev = INIT_MULT * (prev ^ (prev >> 30)) + 32'(k);
                    ring[k / 4][32 * (k % 4) +: 32] = prev;
                end
                read_pos = 0;
                seeds_seen++;
            end else begin
                if (read_pos >= RING_ENTRIES) begin
                    regenerate();
                    read_pos = 0;
                end
                pending_entries.push_back(ring[read_pos]);
                read_pos++;
                fetches_seen++;
            end
        endfunction

        function void check_entry(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                                  logic [31:0] w3);
            logic [127:0] got, want;
            got = {w3, w2, w1, w0};
            if (pending_entries.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected entry %032h with nothing outstanding", got);
                return;
            end
            want = pending_entries.pop_front();
            for (int w = 0; w < 4; w++) begin
                if (got[32*w +: 32] !== want[32*w +: 32]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("entry %0d word%0d: expected %08h, got %08h",
                                 entries_checked, w, want[32*w +: 32], got[32*w +: 32]);
                end
            end
            entries_checked++;
        endfunction

        function int pending();
            return pending_entries.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    simdmt_in_if  cmd_if ();
    simdmt_out_if rnd_if ();

    simd_fast_mersenne_twister dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_if),
        .o_rnd       (rnd_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    rng_scoreboard sb = new();

    // Idling controls. The sender's flag lives in the stimulus process itself; the
    // receiver's flag and the hold-off request are written only by the stimulus process
    // and read by the receiver, each with a nonblocking assignment so that neither
    // depends on the order in which the two processes wake at a clock edge.
    bit tx_gaps_on  = 1'b1;
    bit rx_gaps_on  = 1'b1;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int settings_applied = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Result side. Every transaction on the result channel is compared with the oldest
    // predicted entry. Ready is dropped at random with a probability of one in ten, and for a
    // long unbroken stretch whenever the stimulus process asks for a hold-off, so that
    // the generator backs up and has to stall its command input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rnd_if.ready <= 1'b0;
            hold_seen    <= hold_req;
            hold_left    <= 0;
        end else begin
            if (rnd_if.valid && rnd_if.ready)
                sb.check_entry(rnd_if.word0, rnd_if.word1, rnd_if.word2, rnd_if.word3);
            if (hold_seen != hold_req) begin
                hold_seen    <= hold_req;
                hold_left    <= HOLD_CYCLES;
                rnd_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                rnd_if.ready <= 1'b0;
            end else begin
                rnd_if.ready <= !(rx_gaps_on && $urandom_range(0, 99) < 10);
            end
        end
    end

    // Watchdog: a run that has not finished by now has hung somewhere.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // Offers one command and returns at the clock edge at which it is accepted. The
    // predictor is updated at that same edge, before any result can come back.
    task automatic send_cmd(input t_command cmd, input logic [31:0] seed);
        while (tx_gaps_on && $urandom_range(0, 99) < 10) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.command <= cmd;
        cmd_if.seed    <= seed;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        sb.note_command(cmd, seed);
    endtask

    // A seed value biased towards the all-zeros and all-ones extremes.
    function automatic logic [31:0] pick_seed();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Mostly fetches, so that the read position regularly runs off the end of the ring
    // and forces a regeneration; an occasional reseed restarts the pass.
    task automatic random_item();
        if ($urandom_range(0, 149) == 0)
            send_cmd(CMD_SEED, pick_seed());
        else
            send_cmd(CMD_FETCH, $urandom());
    endtask

    // Stops offering commands, waits for every predicted entry, then gives the block
    // time to finish any seeding or regeneration that produces no result.
    task automatic wait_quiet();
        cmd_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register; the enable is left high so that back-to-back writes never
    // lower and raise it within one time step. The caller drops it afterwards.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        sb.apply_reg(idx, data);
    endtask

    // Programs a full parameter set. The narrow registers get random bits above their
    // width, which the block has to discard, and the undecoded index gets a random write
    // that must change nothing.
    task automatic program_generator(input t_gen_cfg c);
        logic [63:0] junk;
        junk = {$urandom(), $urandom()};
        cfg_write(CFG_PICK_OFFSET,      {junk[63:8], c.pick_offset});
        junk = {$urandom(), $urandom()};
        cfg_write(CFG_WORD_LEFT_SHIFT,  {junk[63:5], c.word_lsh});
        junk = {$urandom(), $urandom()};
        cfg_write(CFG_BYTE_LEFT_SHIFT,  {junk[63:3], c.byte_lsh});
        junk = {$urandom(), $urandom()};
        cfg_write(CFG_WORD_RIGHT_SHIFT, {junk[63:5], c.word_rsh});
        junk = {$urandom(), $urandom()};
        cfg_write(CFG_BYTE_RIGHT_SHIFT, {junk[63:3], c.byte_rsh});
        cfg_write(CFG_MASK_LOW,  c.mask_lo);
        cfg_write(CFG_MASK_HIGH, c.mask_hi);
        cfg_write(CFG_UNUSED_INDEX, {$urandom(), $urandom()});
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    function automatic t_gen_cfg random_cfg();
        t_gen_cfg c;
        c.pick_offset = 8'($urandom_range(0, 255));
        c.word_lsh    = 5'($urandom_range(0, 31));
        c.byte_lsh    = 3'($urandom_range(0, 7));
        c.word_rsh    = 5'($urandom_range(0, 31));
        c.byte_rsh    = 3'($urandom_range(0, 7));
        c.mask_lo     = {$urandom(), $urandom()};
        c.mask_hi     = {$urandom(), $urandom()};
        return c;
    endfunction

    // One stretch of random commands under a fresh parameter set. A hold-off on the
    // result side can be requested at the start, and the sender can pause half way
    // until everything outstanding has come back.
    task automatic run_phase(input t_gen_cfg c, input bit reseed, input bit hold_rx,
                             input bit pause_mid);
        wait_quiet();
        program_generator(c);
        if (hold_rx)
            hold_req <= hold_req + 1;
        if (reseed)
            send_cmd(CMD_SEED, pick_seed());
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (pause_mid && n == PHASE_ITEMS / 2) begin
                cmd_if.valid <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
            end
            random_item();
        end
    endtask

    initial begin
        t_gen_cfg c;

        i_rst_n        = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.command = CMD_FETCH;
        cmd_if.seed    = '0;
        rnd_if.ready   = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_PICK_OFFSET;
        cfg_wdata      = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, under the reset parameters. Fetching before any seed must
        // return the all-zero ring; then seeds at the extremes of the field and two others,
        // each followed by a few fetches from the start of the unmixed first pass.
        send_cmd(CMD_FETCH, 32'hFFFF_FFFF);
        send_cmd(CMD_FETCH, 32'h0000_0000);
        send_cmd(CMD_SEED,  32'h0000_0000);
        repeat (3) send_cmd(CMD_FETCH, $urandom());
        send_cmd(CMD_SEED,  32'hFFFF_FFFF);
        repeat (3) send_cmd(CMD_FETCH, $urandom());
        send_cmd(CMD_SEED,  32'h8000_0001);
        repeat (2) send_cmd(CMD_FETCH, $urandom());
        send_cmd(CMD_SEED,  32'd5489);
        repeat (4) send_cmd(CMD_FETCH, $urandom());

        // Reset parameters written back explicitly, running through more than one pass.
        c = '{8'd1, 5'd11, 3'd7, 5'd7, 3'd7, 64'h0000_0007_0000_0007,
              64'h0000_0007_0000_0007};
        run_phase(c, 1'b0, 1'b0, 1'b0);

        // Everything at zero: both byte shifts and both word shifts vanish, the offset
        // of zero picks the current entry, and the masks remove the offset term.
        c = '{8'd0, 5'd0, 3'd0, 5'd0, 3'd0, 64'h0, 64'h0};
        run_phase(c, 1'b1, 1'b0, 1'b0);

        // Everything at its maximum, offset far beyond the ring size so that it wraps.
        // The result side holds off for a long stretch at the start of this phase.
        c = '{8'd255, 5'd31, 3'd7, 5'd31, 3'd7, '1, '1};
        run_phase(c, 1'b0, 1'b1, 1'b0);

        // Offset equal to the ring size, which reduces to the current entry; the
        // sender stops half way and waits for every outstanding entry.
        c = '{8'(RING_ENTRIES), 5'd1, 3'd1, 5'd1, 3'd1, {$urandom(), $urandom()},
              {$urandom(), $urandom()}};
        run_phase(c, 1'b1, 1'b0, 1'b1);

        // Offset two short of the ring size, with no idling on either side at all.
        tx_gaps_on = 1'b0;
        rx_gaps_on <= 1'b0;
        c = random_cfg();
        c.pick_offset = 8'(RING_ENTRIES - 2);
        run_phase(c, 1'b0, 1'b0, 1'b0);
        tx_gaps_on = 1'b1;
        rx_gaps_on <= 1'b1;

        // Fully random parameter sets, one of them with the offset just short of a
        // whole ring.
        c = random_cfg();
        c.pick_offset = 8'(RING_ENTRIES - 1);
        run_phase(c, 1'b1, 1'b0, 1'b0);
        run_phase(random_cfg(), 1'b0, 1'b0, 1'b0);

        wait_quiet();
        $display("Covered %0d seed and %0d fetch transactions under %0d parameter sets,",
                 sb.seeds_seen, sb.fetches_seen, settings_applied + 1);
        $display("with %0d ring regenerations and %0d entries compared, %0d mismatches.",
                 sb.passes_regenerated, sb.entries_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/simdmt_pkg.sv
design/simdmt_if.sv
design/simdmt_ram.sv
design/simdmt_ctrl.sv
design/simdmt_dp.sv
design/simd_fast_mersenne_twister.sv
dv/tb.sv
